### hdl/ihex_pkg.sv
// Shared constants, types and helpers of the hex record loader.
`default_nettype none
package ihex_pkg;

  localparam int RECORD_BYTES_DEF = 260;
  // Sweep index width: covers the longest checksum sweep (255 + 5 bytes).
  localparam int SWEEP_W = 9;

  localparam logic [7:0] CHAR_COLON  = 8'h3A;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CLOSE  = 8'hFF;
  localparam logic [7:0] HEX_LO      = 8'h30;
  localparam logic [7:0] HEX_HI      = 8'h66;
  localparam logic [7:0] HEX_ALPHA   = 8'h3A;
  localparam logic [4:0] HEX_ALPHA_OFS = 5'h09;
  localparam logic [31:0] WORD_ONES  = 32'hFFFF_FFFF;

  localparam logic [2:0] KIND_WRITE    = 3'd0;
  localparam logic [2:0] KIND_SKIP     = 3'd1;
  localparam logic [2:0] KIND_CSUM_ERR = 3'd2;
  localparam logic [2:0] KIND_EOF      = 3'd3;
  localparam logic [2:0] KIND_OTHER    = 3'd4;
  localparam logic [2:0] KIND_OVERFLOW = 3'd5;

  localparam logic [7:0] REC_DATA    = 8'd0;
  localparam logic [7:0] REC_EOF     = 8'd1;
  localparam logic [7:0] REC_SEGMENT = 8'd2;
  localparam logic [7:0] REC_LINEAR  = 8'd4;

  localparam logic [1:0] CFG_APP_LO  = 2'd0;
  localparam logic [1:0] CFG_APP_HI  = 2'd1;
  localparam logic [1:0] CFG_PROT_LO = 2'd2;
  localparam logic [1:0] CFG_PROT_HI = 2'd3;

  typedef struct packed {
    logic [31:0] app_lo;
    logic [31:0] app_hi;
    logic [31:0] prot_lo;
    logic [31:0] prot_hi;
  } cfg_t;

  typedef struct packed {
    logic close;
    logic overflow;
  } rx_event_t;

  // Nibble value of a character in the convertible range; letters may exceed 15.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] low;
    low = {1'b0, c[3:0]};
    if (c < HEX_ALPHA) return low;
    return HEX_ALPHA_OFS + low;
  endfunction

endpackage
`default_nettype wire

### hdl/intel_hex_record_loader_core.sv
// Top level of the hex record loader: config registers, store, front end, engine.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  input   | in        | in_valid / in_stall    | char_in
//  output  | out       | out_valid / out_stall  | kind, word_address, word_data, last_of_run
//  config  | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Characters inside a record transfer at one per cycle; each hex nibble is written
// straight into the record store RAM, so no cycle is spent outside the close.
// A closing character starts a checksum sweep over the store through its single read
// port, then reads the bytes of each data word (take = bytes in the word) and emits it,
// waiting on out_stall. Input is stalled while the engine works; a result waiting in
// the output register does not stall the input. Synchronous reset clears framing and
// bases and sets config to defaults (app_hi all ones); the store holds no reset value.
`default_nettype none
module intel_hex_record_loader_core import ihex_pkg::*; #(
  parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  char_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [2:0]  kind,
  output logic      [31:0] word_address,
  output logic      [31:0] word_data,
  output logic             last_of_run,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int ADDR_W = $clog2(RECORD_BYTES);

  cfg_t              cfg;
  rx_event_t         ev;
  logic              busy;
  logic              accept;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;

  // The user must issue config writes only while idle; the block does not enforce it; always take them.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.app_lo  <= '0;
      cfg.app_hi  <= WORD_ONES;
      cfg.prot_lo <= '0;
      cfg.prot_hi <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_APP_LO:  cfg.app_lo  <= cfg_data;
        CFG_APP_HI:  cfg.app_hi  <= cfg_data;
        CFG_PROT_LO: cfg.prot_lo <= cfg_data;
        CFG_PROT_HI: cfg.prot_hi <= cfg_data;
      endcase
    end
  end

  // Hold characters back while the engine sweeps the store or emits results.
  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;

  ihex_rx #(
    .RECORD_BYTES(RECORD_BYTES)
  ) u_rx (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .char_in (char_in),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .ev      (ev)
  );

  ihex_ram #(
    .WIDTH(8),
    .DEPTH(RECORD_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  ihex_eng #(
    .RECORD_BYTES(RECORD_BYTES)
  ) u_eng (
    .clk          (clk),
    .rst          (rst),
    .ev           (ev),
    .cfg          (cfg),
    .raddr        (raddr),
    .rdata        (rdata),
    .busy         (busy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .word_address (word_address),
    .word_data    (word_data),
    .last_of_run  (last_of_run)
  );

endmodule
`default_nettype wire

### hdl/ihex_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ihex_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 260,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hdl/ihex_rx.sv
// Character front end: record framing, hex conversion and record store writes.
`default_nettype none
module ihex_rx import ihex_pkg::*; #(
  parameter int RECORD_BYTES = RECORD_BYTES_DEF,
  localparam int ADDR_W = $clog2(RECORD_BYTES),
  localparam int CNT_W  = $clog2(2 * RECORD_BYTES + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [7:0]        char_in,
  output logic                   we,
  output logic      [ADDR_W-1:0] waddr,
  output logic      [7:0]        wdata,
  output rx_event_t              ev
);

  logic             in_record;
  logic             stopped;
  logic [CNT_W-1:0] cnt;
  logic [3:0]       hi;

  logic [4:0] nib;
  logic       is_hex;
  logic       is_close;
  logic       cnt_full;

  assign nib      = hex_nibble(char_in);
  assign is_hex   = (char_in >= HEX_LO) && (char_in <= HEX_HI);
  assign is_close = (char_in == CHAR_LF) || (char_in == CHAR_CLOSE);
  assign cnt_full = cnt >= CNT_W'(2 * RECORD_BYTES);

  assign waddr = cnt[ADDR_W:1];
  // Odd nibble: complete the byte, ORing the whole nibble value in.
  assign wdata = cnt[0] ? ({hi, 4'h0} | {3'b000, nib}) : {nib[3:0], 4'h0};

  always_comb begin
    we          = 1'b0;
    ev.close    = 1'b0;
    ev.overflow = 1'b0;
    if (accept && in_record) begin
      if (is_close) begin
        ev.close = 1'b1;
      end else if (!stopped && is_hex) begin
        if (cnt_full) begin
          ev.overflow = 1'b1;
        end else begin
          we = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_record <= 1'b0;
      stopped   <= 1'b0;
      cnt       <= '0;
    end else if (accept) begin
      priority if (!in_record) begin
        if (char_in == CHAR_COLON) begin
          in_record <= 1'b1;
          stopped   <= 1'b0;
          cnt       <= '0;
        end
      end else if (is_close) begin
        in_record <= 1'b0;
      end else if (stopped) begin
        in_record <= 1'b1;
      end else if (!is_hex) begin
        stopped <= 1'b1;
      end else if (cnt_full) begin
        in_record <= 1'b0;
      end else begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we && !cnt[0]) begin
      hi <= nib[3:0];
    end
  end

endmodule
`default_nettype wire

### hdl/ihex_eng.sv
// Record close engine: checksum sweep, address bases, word emission and status results.
`default_nettype none
module ihex_eng import ihex_pkg::*; #(
  parameter int RECORD_BYTES = RECORD_BYTES_DEF,
  localparam int ADDR_W = $clog2(RECORD_BYTES)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  rx_event_t              ev,
  input  cfg_t                   cfg,
  output logic      [ADDR_W-1:0] raddr,
  input  wire logic [7:0]        rdata,
  output logic                   busy,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [2:0]        kind,
  output logic      [31:0]       word_address,
  output logic      [31:0]       word_data,
  output logic                   last_of_run
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SUM    = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_WBYTE  = 3'd3;
  localparam logic [2:0] ST_WPUT   = 3'd4;
  localparam logic [2:0] ST_RESULT = 3'd5;

  logic [2:0]         state;
  logic [SWEEP_W-1:0] idx;
  logic [SWEEP_W-1:0] idx_d;
  logic               dvalid;
  logic [7:0]         sum;
  logic [7:0]         len;
  logic [7:0]         hdr1, hdr2, rtype, hdr4, hdr5;
  logic [31:0]        lin_base;
  logic [31:0]        seg_base;
  logic [31:0]        cur_addr;
  logic [7:0]         rem;
  logic [2:0]         ic;
  logic [2:0]         ac;
  logic [31:0]        word;
  logic [2:0]         pend_kind;

  logic [7:0]         byte_in;
  logic [7:0]         len_eff;
  logic [SWEEP_W-1:0] lim;
  logic [2:0]         take;
  logic               issuing;
  logic               out_free;
  logic               loading;
  logic               may_write;

  assign byte_in  = (idx_d < SWEEP_W'(RECORD_BYTES)) ? rdata : 8'h00;
  assign len_eff  = (idx_d == '0) ? byte_in : len;
  assign lim      = {1'b0, len_eff} + SWEEP_W'(4);
  assign take     = (rem < 8'd4) ? rem[2:0] : 3'd4;
  assign issuing  = (state == ST_SUM) || ((state == ST_WBYTE) && (ic < take));
  assign out_free = !out_valid || !out_stall;
  assign loading  = out_free && ((state == ST_WPUT) || (state == ST_RESULT));
  assign raddr    = (idx < SWEEP_W'(RECORD_BYTES)) ? idx[ADDR_W-1:0] : '0;
  assign busy     = state != ST_IDLE;
  assign may_write = (cur_addr >= cfg.app_lo) && (cur_addr <= cfg.app_hi) &&
                     !((cur_addr >= cfg.prot_lo) && (cur_addr <= cfg.prot_hi));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      dvalid    <= 1'b0;
      lin_base  <= '0;
      seg_base  <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= loading || (out_valid && out_stall);
      dvalid <= issuing;
      idx_d  <= idx;
      if (issuing) begin
        idx <= idx + SWEEP_W'(1);
      end
      unique case (state)
        ST_IDLE: begin
          if (ev.close) begin
            state <= ST_SUM;
            idx   <= '0;
            sum   <= 8'h00;
          end else if (ev.overflow) begin
            pend_kind <= KIND_OVERFLOW;
            state     <= ST_RESULT;
          end
        end
        ST_SUM: begin
          if (dvalid) begin
            if (idx_d <= lim) begin
              sum <= sum + byte_in;
            end
            unique case (idx_d)
              SWEEP_W'(0): len   <= byte_in;
              SWEEP_W'(1): hdr1  <= byte_in;
              SWEEP_W'(2): hdr2  <= byte_in;
              SWEEP_W'(3): rtype <= byte_in;
              SWEEP_W'(4): hdr4  <= byte_in;
              SWEEP_W'(5): hdr5  <= byte_in;
              default: ;
            endcase
            if ((idx_d >= SWEEP_W'(5)) && (idx_d >= lim)) begin
              state <= ST_DECIDE;
            end
          end
        end
        ST_DECIDE: begin
          if (sum != 8'h00) begin
            pend_kind <= KIND_CSUM_ERR;
            state     <= ST_RESULT;
          end else if (rtype == REC_DATA) begin
            if (len != 8'h00) begin
              cur_addr <= {16'h0000, hdr1, hdr2} + lin_base + seg_base;
              rem      <= len;
              idx      <= SWEEP_W'(4);
              ic       <= 3'd0;
              ac       <= 3'd0;
              word     <= WORD_ONES;
              state    <= ST_WBYTE;
            end else begin
              pend_kind <= KIND_OTHER;
              state     <= ST_RESULT;
            end
          end else if (rtype == REC_SEGMENT) begin
            seg_base  <= {12'h000, hdr4, hdr5, 4'h0};
            lin_base  <= '0;
            pend_kind <= KIND_OTHER;
            state     <= ST_RESULT;
          end else if (rtype == REC_LINEAR) begin
            lin_base  <= {hdr4, hdr5, 16'h0000};
            seg_base  <= '0;
            pend_kind <= KIND_OTHER;
            state     <= ST_RESULT;
          end else begin
            lin_base  <= '0;
            seg_base  <= '0;
            pend_kind <= (rtype == REC_EOF) ? KIND_EOF : KIND_OTHER;
            state     <= ST_RESULT;
          end
        end
        ST_WBYTE: begin
          if (issuing) begin
            ic <= ic + 3'd1;
          end
          if (dvalid) begin
            word[{ac[1:0], 3'b000} +: 8] <= byte_in;
            ac <= ac + 3'd1;
            if ((ac + 3'd1) == take) begin
              state <= ST_WPUT;
            end
          end
        end
        ST_WPUT: begin
          if (out_free) begin
            kind         <= may_write ? KIND_WRITE : KIND_SKIP;
            word_address <= cur_addr;
            word_data    <= word;
            last_of_run  <= rem <= 8'd4;
            cur_addr     <= cur_addr + 32'd4;
            rem          <= rem - {5'b00000, take};
            if (rem <= 8'd4) begin
              state <= ST_IDLE;
            end else begin
              ic    <= 3'd0;
              ac    <= 3'd0;
              word  <= WORD_ONES;
              state <= ST_WBYTE;
            end
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            kind         <= pend_kind;
            word_address <= '0;
            word_data    <= '0;
            last_of_run  <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/ihex_checker.sv
// Port-level checker for the hex record loader, bound to the top level.
`default_nettype none
module ihex_port_checker import ihex_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  kind,
  input wire logic [31:0] word_address,
  input wire logic [31:0] word_data,
  input wire logic        last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_CSUM_ERR || kind == KIND_EOF ||
                  kind == KIND_OTHER || kind == KIND_OVERFLOW)
    |-> word_address == 32'd0 && word_data == 32'd0)
    else $error("status result carries address or data");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_CSUM_ERR || kind == KIND_EOF ||
                  kind == KIND_OTHER || kind == KIND_OVERFLOW)
    |-> last_of_run)
    else $error("status result not marked last");

  a_new_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result produced while input was not held");

endmodule

bind intel_hex_record_loader_core ihex_port_checker u_ihex_checker (.*);
`default_nettype wire
